### design/pdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared types and constants of the preamble detector: payload widths, the
// configuration register map and the width of the length compare.
// ----------------------------------------------------------------------------
package pdt_pkg;

	// Width of the symbol field on the input channel.
	localparam int SYMBOL_W = 8;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Preamble storage: four words of eight byte-wide symbols.
	localparam int PAT_WORDS     = 4;
	localparam int PAT_WORD_W    = 64;
	localparam int PAT_STORED    = 32;

	// Width of an effective pattern length (up to 63 symbols).
	localparam int LEN_W = 7;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LENGTH    = 3'd0,
		REG_WORD0     = 3'd1,
		REG_WORD1     = 3'd2,
		REG_WORD2     = 3'd3,
		REG_WORD3     = 3'd4,
		REG_TOLERANCE = 3'd5,
		REG_HOLDOFF   = 3'd6
	} cfg_reg_t;

endpackage
`default_nettype wire

### design/pdt_symbol_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_symbol_if
// Valid/ready channel that carries one received symbol per transaction.
// ----------------------------------------------------------------------------
interface pdt_symbol_if;
	logic                        valid;
	logic                        ready;
	logic [pdt_pkg::SYMBOL_W-1:0] symbol;

	modport source (output valid, output symbol, input ready);
	modport sink   (input valid, input symbol, output ready);
endinterface
`default_nettype wire

### design/pdt_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_result_if
// Valid/ready channel that carries one detection flag per transaction.
// ----------------------------------------------------------------------------
interface pdt_result_if;
	logic valid;
	logic ready;
	logic detected;

	modport source (output valid, output detected, input ready);
	modport sink   (input valid, input detected, output ready);
endinterface
`default_nettype wire

### design/preamble_detector_with_tolerance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// preamble_detector_with_tolerance
// Sliding-window preamble correlator with a mismatch tolerance and hold-off.
// ----------------------------------------------------------------------------
// An accepted symbol passes the compare, group and sum states, then waits in
// the decide state while the last result is unread. The compare, count and
// decide pipeline runs for one symbol at a time, because the hold-off counter
// set by one symbol gates the decision of the next.
// Reset: control, fill count and hold-off clear at once; configuration
// registers take their reset values; window contents stay undefined.
// ----------------------------------------------------------------------------
module preamble_detector_with_tolerance #(
	parameter int MAX_PATTERN = 32,
	parameter int SYMBOL_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	pdt_symbol_if.sink                           symbols,
	pdt_result_if.source                         results,
	input  wire logic                            cfg_we,
	input  wire logic [pdt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pdt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int LEN_W  = pdt_pkg::LEN_W;
	localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
	localparam int VEC_W  = MAX_PATTERN * SYMBOL_BITS;
	localparam int SH_W   = $clog2(VEC_W + 1);
	localparam int PROD_W = CNT_W + 8;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CMP    = 5'b00010,
		ST_GRP    = 5'b00100,
		ST_SUM    = 5'b01000,
		ST_DECIDE = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [5:0]                     len_q;
	logic [pdt_pkg::PAT_WORD_W-1:0] pat_word_q [pdt_pkg::PAT_WORDS];
	logic [7:0]                     tol_q;
	logic [15:0]                    hold_len_q;

	// Datapath and control state.
	logic [CNT_W-1:0]       fill_q;
	logic [15:0]            hold_q;
	logic                   out_valid_q;
	logic                   det_q;
	logic [VEC_W-1:0]       rev_pat;
	logic [VEC_W-1:0]       aligned_q;
	logic [SH_W-1:0]        align_sh;
	logic [LEN_W-1:0]       len_eff;
	logic                   accept;
	logic                   decide;
	logic                   warm;
	logic [CNT_W-1:0]       wrong;
	logic [PROD_W-1:0]      prod;
	logic                   det_d;
	logic [15:0]            hold_d;
	logic [SYMBOL_BITS-1:0] win     [MAX_PATTERN];
	logic [SYMBOL_BITS-1:0] shift_d [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] mism;

	assign accept = symbols.valid && symbols.ready;
	assign decide = (state_q == ST_DECIDE) && (!out_valid_q || results.ready);

	assign symbols.ready    = (state_q == ST_IDLE);
	assign results.valid    = out_valid_q;
	assign results.detected = det_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= 6'd32;
			tol_q      <= 8'd1;
			hold_len_q <= 16'd1;
			for (int w = 0; w < pdt_pkg::PAT_WORDS; w++) begin
				pat_word_q[w] <= '0;
			end
		end else if (cfg_we) begin
			case (pdt_pkg::cfg_reg_t'(cfg_index))
				pdt_pkg::REG_LENGTH:    len_q         <= cfg_data[5:0];
				pdt_pkg::REG_WORD0:     pat_word_q[0] <= cfg_data;
				pdt_pkg::REG_WORD1:     pat_word_q[1] <= cfg_data;
				pdt_pkg::REG_WORD2:     pat_word_q[2] <= cfg_data;
				pdt_pkg::REG_WORD3:     pat_word_q[3] <= cfg_data;
				pdt_pkg::REG_TOLERANCE: tol_q         <= cfg_data[7:0];
				pdt_pkg::REG_HOLDOFF:   hold_len_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Length clamped to the window size.
	assign len_eff = (LEN_W'(len_q) > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
	                                                         : LEN_W'(len_q);

	// Preamble in reversed symbol order; symbols beyond the stored ones are zero.
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_rev
		if (j < pdt_pkg::PAT_STORED) begin : g_stored
			assign rev_pat[(MAX_PATTERN-1-j)*SYMBOL_BITS +: SYMBOL_BITS] =
				pat_word_q[j >> 3][(j & 7) * 8 +: SYMBOL_BITS];
		end else begin : g_zero
			assign rev_pat[(MAX_PATTERN-1-j)*SYMBOL_BITS +: SYMBOL_BITS] = '0;
		end
	end

	// Align the preamble so that cell i sees pattern symbol len-1-i.
	assign align_sh = SH_W'(LEN_W'(MAX_PATTERN) - len_eff) * SH_W'(SYMBOL_BITS);

	always_ff @(posedge clk) begin
		aligned_q <= rev_pat >> align_sh;
	end

	// Row of window cells, newest symbol in cell 0.
	assign shift_d[0] = symbols.symbol[SYMBOL_BITS-1:0];
	for (genvar i = 1; i < MAX_PATTERN; i++) begin : g_link
		assign shift_d[i] = win[i-1];
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		pdt_cell #(
			.SYMBOL_BITS (SYMBOL_BITS),
			.INDEX       (i)
		) u_cell (
			.clk      (clk),
			.shift_en (accept),
			.d        (shift_d[i]),
			.pat      (aligned_q[i*SYMBOL_BITS +: SYMBOL_BITS]),
			.len      (len_eff),
			.q        (win[i]),
			.mism     (mism[i])
		);
	end

	// Mismatch count.
	pdt_popcount #(
		.WIDTH (MAX_PATTERN)
	) u_popcount (
		.clk   (clk),
		.flags (mism),
		.count (wrong)
	);

	// Match decision and hold-off update.
	assign warm = LEN_W'(fill_q) < len_eff;
	assign prod = PROD_W'(wrong) * PROD_W'(tol_q);

	always_comb begin
		det_d  = 1'b0;
		hold_d = hold_q;
		if (!warm) begin
			if (hold_q != 16'd0) begin
				det_d  = (hold_q == hold_len_q);
				hold_d = hold_q - 16'd1;
			end else if ((len_eff != '0) && (prod < PROD_W'(len_eff))) begin
				hold_d = hold_len_q;
			end
		end
	end

	// Sequencer, fill count, hold-off and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
						if (fill_q < CNT_W'(MAX_PATTERN)) begin
							fill_q <= fill_q + CNT_W'(1);
						end
					end
				end
				ST_CMP:    state_q <= ST_GRP;
				ST_GRP:    state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (decide) begin
						state_q <= ST_IDLE;
						hold_q  <= hold_d;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase

			if (decide) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			det_q <= det_d;
		end
	end

	// An accepted symbol reaches the decision stage after the compare, group and sum states.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 (state_q == ST_DECIDE))
		else $error("accepted symbol did not reach the decision stage");

	// The fill count never passes the window size.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_PATTERN))
		else $error("fill count beyond window size");

	// A detection is only reported on the first decided symbol of a running hold-off.
	assert property (@(posedge clk) disable iff (!arst_n)
		(decide && det_d) |-> (hold_q != 16'd0) && (hold_q == hold_len_q) && !warm)
		else $error("detection reported outside the first hold-off item");

	// A running hold-off counts down by one per decided symbol.
	assert property (@(posedge clk) disable iff (!arst_n)
		(decide && !warm && (hold_q != 16'd0)) |=> (hold_q == $past(hold_q) - 16'd1))
		else $error("hold-off counter did not decrement");

endmodule
`default_nettype wire

### design/pdt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_cell
// One position of the sliding window. It holds a symbol, passes it to the
// next cell on every shift and flags a mismatch against its pattern symbol.
// ----------------------------------------------------------------------------
module pdt_cell #(
	parameter int SYMBOL_BITS = 8,
	parameter int INDEX       = 0
) (
	input  wire logic                       clk,
	input  wire logic                       shift_en,
	input  wire logic [SYMBOL_BITS-1:0]     d,
	input  wire logic [SYMBOL_BITS-1:0]     pat,
	input  wire logic [pdt_pkg::LEN_W-1:0]  len,
	output logic      [SYMBOL_BITS-1:0]     q,
	output logic                            mism
);

	logic [SYMBOL_BITS-1:0] sym_q;
	logic                   mism_s1;
	logic                   active;

	// The cell takes part in the compare only inside the configured length.
	assign active = pdt_pkg::LEN_W'(INDEX) < len;

	// Window symbol, shifted in from the neighbor on each transaction.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sym_q <= d;
		end
	end

	// Registered mismatch flag for the population count.
	always_ff @(posedge clk) begin
		mism_s1 <= active && (sym_q != pat);
	end

	assign q    = sym_q;
	assign mism = mism_s1;

endmodule
`default_nettype wire

### design/pdt_popcount.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_popcount
// Two-stage registered count of the mismatch flags: byte-wide group sums,
// then the sum of the groups.
// ----------------------------------------------------------------------------
module pdt_popcount #(
	parameter int WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic [WIDTH-1:0]           flags,
	output logic      [$clog2(WIDTH+1)-1:0] count
);

	localparam int NGRP = (WIDTH + 7) / 8;
	localparam int PW   = NGRP * 8;
	localparam int CW   = $clog2(WIDTH + 1);

	logic [PW-1:0] padded;
	logic [3:0]    grp_d  [NGRP];
	logic [3:0]    grp_s2 [NGRP];
	logic [CW-1:0] total_d;
	logic [CW-1:0] total_s3;

	assign padded = PW'(flags);

	// Sum each group of eight flags.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = 4'd0;
			for (int b = 0; b < 8; b++) begin
				grp_d[g] = grp_d[g] + 4'(padded[g*8+b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s2 <= grp_d;
	end

	// Add the group sums.
	always_comb begin
		total_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			total_d = total_d + CW'(grp_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		total_s3 <= total_d;
	end

	assign count = total_s3;

endmodule
`default_nettype wire

### tb/pdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_checker
// Watches the symbol, result and configuration ports of the preamble detector.
// It keeps its own copy of the window, fill count, hold-off and registers,
// predicts the detection flag of every accepted symbol, and compares each
// accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pdt_checker
	import pdt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	pdt_symbol_if                 syms,
	pdt_result_if                 results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding
);

	localparam int WIN_DEPTH = 32;

	// Shadow copy of the configuration registers.
	logic [5:0]            cfg_len;
	logic [PAT_WORD_W-1:0] cfg_pattern [PAT_WORDS];
	logic [7:0]            cfg_rate;
	logic [15:0]           cfg_holdoff;

	// Shadow copy of the correlator state.
	logic [SYMBOL_W-1:0]   win_syms [WIN_DEPTH];
	int                    syms_seen;
	logic [15:0]           holdoff_left;

	// Detection flags predicted for accepted symbols, oldest first.
	bit                    detect_queue [$];
	bit                    want_detect;

	initial fail_count = 0;

	// Shift one symbol into the window and work out the flag it produces.
	function automatic bit correlate_symbol(input logic [SYMBOL_W-1:0] sym);
		int eff;
		int wrong;
		int i;
		bit pulse;
		eff = (cfg_len > WIN_DEPTH) ? WIN_DEPTH : int'(cfg_len);
		for (i = WIN_DEPTH - 1; i > 0; i--)
			win_syms[i] = win_syms[i-1];
		win_syms[0] = sym;
		if (syms_seen < WIN_DEPTH)
			syms_seen++;
		// Still filling the window.
		if (syms_seen < eff)
			return 1'b0;
		// Hold-off running: pulse only on its first item, no comparison.
		if (holdoff_left != 16'd0) begin
			pulse = (holdoff_left == cfg_holdoff);
			holdoff_left = holdoff_left - 16'd1;
			return pulse;
		end
		if (eff == 0)
			return 1'b0;
		// Compare oldest symbol first against preamble symbol zero.
		wrong = 0;
		for (i = 0; i < eff; i++) begin
			if (win_syms[eff-1-i] != cfg_pattern[i/8][(i%8)*8 +: 8])
				wrong++;
		end
		if (wrong * int'(cfg_rate) < eff)
			holdoff_left = cfg_holdoff;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len      = 6'd32;
			cfg_pattern  = '{default: '0};
			cfg_rate     = 8'd1;
			cfg_holdoff  = 16'd1;
			win_syms     = '{default: '0};
			syms_seen    = 0;
			holdoff_left = 16'd0;
			detect_queue.delete();
			outstanding  = 0;
		end else begin
			// Compare a result transaction with the oldest prediction.
			if (results.valid && results.ready) begin
				if (detect_queue.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual %b",
						$time, results.detected);
					fail_count++;
				end else begin
					want_detect = detect_queue.pop_front();
					if (results.detected !== want_detect) begin
						$display("%0t: detected mismatch, expected %b, actual %b",
							$time, want_detect, results.detected);
						fail_count++;
					end
				end
			end

			// Track register writes.
			if (cfg_we) begin
				case (cfg_index)
					REG_LENGTH:    cfg_len        = cfg_data[5:0];
					REG_WORD0:     cfg_pattern[0] = cfg_data;
					REG_WORD1:     cfg_pattern[1] = cfg_data;
					REG_WORD2:     cfg_pattern[2] = cfg_data;
					REG_WORD3:     cfg_pattern[3] = cfg_data;
					REG_TOLERANCE: cfg_rate       = cfg_data[7:0];
					REG_HOLDOFF:   cfg_holdoff    = cfg_data[15:0];
					default:       ;
				endcase
			end

			// Predict the flag of every accepted symbol transaction.
			if (syms.valid && syms.ready)
				detect_queue.push_back(correlate_symbol(syms.symbol));

			outstanding = detect_queue.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the preamble detector. A short directed part walks
// the warm-up, hold-off, zero length and zero tolerance cases; then random
// phases, each with its own register setting, send preambles with a few
// corrupted symbols mixed with noise and cut-off preambles, under random
// idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
	import pdt_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int NUM_PHASES   = 14;
	localparam int PHASE_ITEMS  = 86;
	localparam int IDLE_PERCENT = 18;
	localparam int STALL_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    outstanding;

	pdt_symbol_if sym_if ();
	pdt_result_if res_if ();

	// Stimulus bookkeeping.
	logic [PAT_WORD_W-1:0] pat_words [PAT_WORDS];
	int                    items_sent;
	int                    cycle_count;
	bit                    steady;
	bit                    hold_request;
	bit                    hold_done;
	int                    stall_left;
	int                    phase;
	int                    phase_len;
	int                    phase_eff;
	int                    phase_rate;
	int                    phase_hold;
	int                    phase_end;
	int                    pick;
	int                    k;

	preamble_detector_with_tolerance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.symbols   (sym_if),
		.results   (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pdt_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.syms        (sym_if),
		.results     (res_if),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Result receiver: random back-pressure, one long stall on request.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_if.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			stall_left = STALL_CYCLES - 1;
			res_if.ready <= 1'b0;
		end else if (steady) begin
			res_if.ready <= 1'b1;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Write one register; called at a falling edge, returns at the next one.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Program every register; the preamble comes from pat_words.
	task automatic apply_setting(input int len, input int rate, input int hold);
		write_reg(REG_LENGTH, CFG_DATA_W'(len));
		write_reg(REG_WORD0, pat_words[0]);
		write_reg(REG_WORD1, pat_words[1]);
		write_reg(REG_WORD2, pat_words[2]);
		write_reg(REG_WORD3, pat_words[3]);
		write_reg(REG_TOLERANCE, CFG_DATA_W'(rate));
		write_reg(REG_HOLDOFF, CFG_DATA_W'(hold));
		cfg_we <= 1'b0;
	endtask

	// Offer one symbol until it is accepted, with random gaps before it.
	task automatic send_symbol(input logic [SYMBOL_W-1:0] sym);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			sym_if.valid <= 1'b0;
			@(negedge clk);
		end
		sym_if.valid  <= 1'b1;
		sym_if.symbol <= sym;
		@(posedge clk);
		while (!sym_if.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Send the first count symbols of the preamble with a few corrupted.
	task automatic send_preamble(input int eff, input int errors, input int count);
		logic [SYMBOL_W-1:0] frame [32];
		int i;
		int pos;
		for (i = 0; i < eff; i++)
			frame[i] = pat_words[i/8][(i%8)*8 +: 8];
		repeat (errors) begin
			pos = $urandom_range(0, eff - 1);
			frame[pos] = frame[pos] ^ SYMBOL_W'($urandom_range(1, 255));
		end
		for (i = 0; i < count; i++)
			send_symbol(frame[i]);
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain();
		sym_if.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		sym_if.valid  = 1'b0;
		sym_if.symbol = '0;
		res_if.ready  = 1'b0;
		items_sent    = 0;
		cycle_count   = 0;
		steady        = 1'b0;
		hold_request  = 1'b0;
		hold_done     = 1'b0;
		stall_left    = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Four-symbol preamble with extreme bytes, exact match, hold-off of two:
		// warm-up, a match, its pulse, a suppressed item, a mismatch, then a fresh match.
		pat_words = '{64'h0000_0000_5AA5_FF00, 64'h0, 64'h0, 64'h0};
		apply_setting(4, 1, 2);
		repeat (2) begin
			for (k = 0; k < 4; k++)
				send_symbol(pat_words[0][k*8 +: 8]);
		end
		drain();

		// Zero length: nothing can match.
		apply_setting(0, 0, 0);
		send_symbol(8'hFF);
		send_symbol(8'h00);
		send_symbol(8'h80);
		drain();

		// One-symbol preamble with zero tolerance rate: every compare matches.
		apply_setting(1, 0, 3);
		repeat (6) send_symbol(SYMBOL_W'($urandom_range(0, 255)));
		drain();

		// Random phases, each with its own setting.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0:       phase_len = 1;
				1:       phase_len = 32;
				2:       phase_len = $urandom_range(33, 63);
				default: phase_len = ($urandom_range(0, 3) == 0) ?
					$urandom_range(17, 32) : $urandom_range(2, 16);
			endcase
			case (phase)
				3:       phase_rate = 0;
				4:       phase_rate = 255;
				default: phase_rate = $urandom_range(1, 6);
			endcase
			if (phase == 5)
				phase_hold = 0;
			else if (phase == NUM_PHASES - 1)
				phase_hold = 65535;
			else if ($urandom_range(0, 4) == 0)
				phase_hold = $urandom_range(8, 40);
			else
				phase_hold = $urandom_range(1, 6);
			for (k = 0; k < PAT_WORDS; k++) begin
				if (phase == 6)
					pat_words[k] = '1;
				else if (phase == 7)
					pat_words[k] = '0;
				else
					pat_words[k] = {$urandom, $urandom};
			end
			phase_eff = (phase_len > 32) ? 32 : phase_len;

			apply_setting(phase_len, phase_rate, phase_hold);
			steady = (phase == 6);
			if (phase == 8)
				hold_request = 1'b1;

			// Mostly whole preambles, with noise and cut-off preambles between.
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					send_preamble(phase_eff,
						($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3), phase_eff);
					repeat ($urandom_range(0, 2))
						send_symbol(SYMBOL_W'($urandom_range(0, 255)));
				end else if (pick < 8) begin
					repeat ($urandom_range(1, 6))
						send_symbol(SYMBOL_W'($urandom_range(0, 255)));
				end else begin
					send_preamble(phase_eff, $urandom_range(0, 1),
						$urandom_range(0, phase_eff - 1));
					send_symbol(SYMBOL_W'($urandom_range(0, 255)));
				end
			end
			steady = 1'b0;
			drain();
		end

		repeat (20) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### filelist.f
design/pdt_pkg.sv
design/pdt_symbol_if.sv
design/pdt_result_if.sv
design/pdt_cell.sv
design/pdt_popcount.sv
design/preamble_detector_with_tolerance.sv
tb/pdt_checker.sv
tb/tb_top.sv
